/* hdl/palette_color_indexer_assert.svh */
// assertion macros for the palette color indexer checker
`ifndef PALETTE_COLOR_INDEXER_ASSERT_SVH
`define PALETTE_COLOR_INDEXER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCI_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pci_pkg.sv */
// shared constants and types of the palette color indexer
package pci_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned COLOR_W       = 4 * CHAN_W;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned STORE_SLOTS   = 256;
  localparam int unsigned DEFAULT_DEPTH = 256;

  // control broadcast from the sequencer to the cell chain
  typedef struct packed {
    logic inject;  // token enters the first cell
    logic shift;   // tokens move one cell on
    logic clear;   // all tokens drop
    logic write;   // cell holding the token stores the color
  } chain_ctrl_t;

endpackage

/* hdl/palette_color_indexer.sv */
// top level of the palette color indexer
//
// Input channel: one RGBA pixel per transfer (red_i, green_i, blue_i,
// alpha_i, last_pixel_i) under in_valid_i / in_stall_o. Output channel: one
// result per pixel (color_index_o, added_new_o, overflow_o, colors_used_o)
// under out_valid_o / out_stall_i.
// A search token walks a chain of palette cells, one cell per cycle, starting
// at entry 0. It stops at the first cell whose color matches or at the first
// unused cell, where a new color is stored if the palette has room. A pixel
// that matches entry k is offered as a result once the token reaches cell
// k; a pixel with no match once it passes the n entries in use. One pixel is
// in work at a time, so the input stalls until its search ends.
// The result sits in an output register, so the next pixel is taken while it
// waits. If out_stall_i holds a result, a finished search waits for the
// register to free up.
// Reset empties the palette and the output register; stored colors need no
// clearing. After the pixel marked last, the palette count goes back to zero.
module palette_color_indexer #(
  parameter int unsigned PALETTE_DEPTH = pci_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pci_pkg::CHAN_W-1:0]    red_i,
  input  logic [pci_pkg::CHAN_W-1:0]    green_i,
  input  logic [pci_pkg::CHAN_W-1:0]    blue_i,
  input  logic [pci_pkg::CHAN_W-1:0]    alpha_i,
  input  logic                          last_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pci_pkg::INDEX_W-1:0]   color_index_o,
  output logic                          added_new_o,
  output logic                          overflow_o,
  output logic [pci_pkg::COUNT_W-1:0]   colors_used_o
);

  localparam int unsigned CAP = (PALETTE_DEPTH > pci_pkg::STORE_SLOTS) ?
                                pci_pkg::STORE_SLOTS : PALETTE_DEPTH;
  localparam logic [pci_pkg::COUNT_W-1:0] CAP_CNT = pci_pkg::COUNT_W'(CAP);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic [pci_pkg::COLOR_W-1:0]  color_q;
  logic                         last_q;
  logic [pci_pkg::COUNT_W-1:0]  idx_q, idx_d;
  logic [pci_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  logic [pci_pkg::INDEX_W-1:0]  index_q;
  logic                         added_q;
  logic                         over_q;
  logic [pci_pkg::COUNT_W-1:0]  used_q;

  pci_pkg::chain_ctrl_t         ctrl;
  logic                         chain_hit;
  logic                         accept;
  logic                         scanning;
  logic                         miss;
  logic                         done;
  logic                         out_free;
  logic                         finish;
  logic                         room;
  logic [pci_pkg::COUNT_W-1:0]  res_index;
  logic [pci_pkg::COUNT_W-1:0]  res_used;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign scanning   = (state_q == ST_SCAN);

  // search outcome at the cell under the token
  assign miss     = (idx_q == count_q);
  assign done     = miss || chain_hit;
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = scanning && done && out_free;
  assign room     = (count_q < CAP_CNT);

  // chain control
  always_comb begin
    ctrl.inject = accept;
    ctrl.shift  = accept || (scanning && !done);
    ctrl.clear  = finish;
    ctrl.write  = finish && miss && room;
  end

  pci_chain #(
    .CELLS (CAP)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .color_i (color_q),
    .hit_o   (chain_hit)
  );

  // result of the finished search
  always_comb begin
    res_index = idx_q;
    res_used  = count_q;
    if (miss) begin
      if (room) begin
        res_index = count_q;
        res_used  = count_q + pci_pkg::COUNT_W'(1);
      end else begin
        res_index = '0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d = ST_IDLE;
          count_d = last_q ? '0 : res_used;
        end else if (!done) begin
          idx_d = idx_q + pci_pkg::COUNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pixel capture on input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      color_q <= {red_i, green_i, blue_i, alpha_i};
      last_q  <= last_pixel_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (finish) begin
      index_q <= res_index[pci_pkg::INDEX_W-1:0];
      added_q <= miss && room;
      over_q  <= miss && !room;
      used_q  <= res_used;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = index_q;
  assign added_new_o   = added_q;
  assign overflow_o    = over_q;
  assign colors_used_o = used_q;

endmodule

/* hdl/pci_cell.sv */
// one palette cell: a stored color and a search token passed to the next cell
module pci_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pci_pkg::chain_ctrl_t         ctrl_i,
  input  logic                         token_i,
  input  logic [pci_pkg::COLOR_W-1:0]  color_i,
  output logic                         token_o,
  output logic                         hit_o
);

  logic                        token_q, token_d;
  logic [pci_pkg::COLOR_W-1:0] entry_q;

  // token moves along the chain, dropped when the search ends
  always_comb begin
    token_d = token_q;
    if (ctrl_i.clear) begin
      token_d = 1'b0;
    end else if (ctrl_i.shift) begin
      token_d = token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
    end else begin
      token_q <= token_d;
    end
  end

  // stored color, written only where the token sits
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write && token_q) begin
      entry_q <= color_i;
    end
  end

  assign token_o = token_q;
  assign hit_o   = token_q && (entry_q == color_i);

endmodule

/* hdl/pci_chain.sv */
// row of palette cells with the token chain and the hit reduction
module pci_chain #(
  parameter int unsigned CELLS = pci_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pci_pkg::chain_ctrl_t         ctrl_i,
  input  logic [pci_pkg::COLOR_W-1:0]  color_i,
  output logic                         hit_o
);

  logic [CELLS-1:0] token;
  logic [CELLS-1:0] hit;

  // cells, each fed by the token of its left neighbor, the first by inject
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic token_in;
    if (i == 0) begin : g_head
      assign token_in = ctrl_i.inject;
    end else begin : g_body
      assign token_in = token[i-1];
    end
    pci_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .token_i (token_in),
      .color_i (color_i),
      .token_o (token[i]),
      .hit_o   (hit[i])
    );
  end

  // at most one cell holds the token, so an or gives its compare
  assign hit_o = |hit;

endmodule

/* hdl/pci_checker.sv */
// port checker of the palette color indexer and its bind
`include "palette_color_indexer_assert.svh"

module pci_checker #(
  parameter int unsigned PALETTE_DEPTH = pci_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [pci_pkg::CHAN_W-1:0]    red_i,
  input  logic [pci_pkg::CHAN_W-1:0]    green_i,
  input  logic [pci_pkg::CHAN_W-1:0]    blue_i,
  input  logic [pci_pkg::CHAN_W-1:0]    alpha_i,
  input  logic                          last_pixel_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [pci_pkg::INDEX_W-1:0]   color_index_o,
  input  logic                          added_new_o,
  input  logic                          overflow_o,
  input  logic [pci_pkg::COUNT_W-1:0]   colors_used_o
);

  localparam int unsigned CAP = (PALETTE_DEPTH > pci_pkg::STORE_SLOTS) ?
                                pci_pkg::STORE_SLOTS : PALETTE_DEPTH;
  localparam logic [pci_pkg::COUNT_W-1:0] CAP_CNT = pci_pkg::COUNT_W'(CAP);

  logic [pci_pkg::COUNT_W-1:0] index_ext;
  logic                        pixel_seen;

  assign index_ext  = {1'b0, color_index_o};
  assign pixel_seen = |{red_i, green_i, blue_i, alpha_i, last_pixel_i} || 1'b1;

  // a stalled result stays offered
  `PCI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // a pixel in work blocks the next one
  `PCI_ASSERT_NEXT(a_one_in_work, in_valid_i && !in_stall_o && pixel_seen, in_stall_o, "second pixel taken during search")

  // overflow only with a full palette, index zero and nothing appended
  `PCI_ASSERT(a_overflow, out_valid_o && overflow_o, (colors_used_o == CAP_CNT) && (color_index_o == '0) && !added_new_o, "bad overflow result")

  // an appended color lands at the end of the palette
  `PCI_ASSERT(a_added, out_valid_o && added_new_o, colors_used_o == index_ext + pci_pkg::COUNT_W'(1), "appended index not last entry")

  // every stored index lies within the palette in use
  `PCI_ASSERT(a_in_range, out_valid_o && !overflow_o, (index_ext < colors_used_o) && (colors_used_o <= CAP_CNT), "index beyond palette")

endmodule

bind palette_color_indexer pci_checker #(
  .PALETTE_DEPTH (PALETTE_DEPTH)
) u_pci_checker (.*);
